[hw/rtl/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define LZWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition leads to another in the next cycle.
`define LZWD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`endif

[hw/rtl/lzwd_pkg.sv]
// Types and constants of the LZ window decoder.
package lzwd_pkg;

  localparam int unsigned WIN_AW    = 10;
  localparam int unsigned WIN_DEPTH = 1024;
  localparam logic [9:0]  WIN_START = 10'h3BE;
  localparam logic [15:0] FLAG_MARK = 16'hFF00;
  localparam int unsigned LEN_BIAS  = 3;
  localparam int unsigned CNT_W     = 7;

  // configuration register indexes
  localparam logic [2:0] CFG_ORDER  = 3'd0;
  localparam logic [2:0] CFG_LENGTH = 3'd1;
  localparam logic [2:0] CFG_STRIDE = 3'd2;
  localparam logic [2:0] CFG_HEIGHT = 3'd3;

  typedef enum logic [1:0] {PH_FLAG, PH_LIT, PH_HIGH, PH_LOW} phase_e;
  typedef enum logic [1:0] {ST_RUN, ST_DONE, ST_SRC, ST_IDX} status_e;
  typedef enum logic [1:0] {CMD_NOP, CMD_LIT, CMD_COPY} cmd_kind_e;
  typedef enum logic [2:0] {B_IDLE, B_EXEC, B_RD, B_WR, B_FIN} bstate_e;

  typedef struct packed {
    logic              order_mode;
    logic [17:0]       out_length;
    logic [8:0]        row_stride;
    logic [8:0]        column_height;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data;
    logic [9:0]        pos;
    logic [CNT_W-1:0]  cnt;
    logic              start;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [7:0]        byte_a;
    logic [16:0]       index_a;
    logic [7:0]        byte_b;
    logic [16:0]       index_b;
    logic [1:0]        pair_count;
    logic              run_last;
    status_e           status;
    logic [17:0]       used_count;
  } result_t;

endpackage

[hw/rtl/lzwd_ram.sv]
// Generic single write port RAM with a registered read port.
module lzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[hw/rtl/lzwd_fifo.sv]
// Small register FIFO with valid/ready on both sides.
module lzwd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != (AW+1)'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // advance pointers with wrap at the depth
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // hold entry data
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end
endmodule

[hw/rtl/lzwd_front.sv]
// Front end: parses flag bytes and code words into decode commands.
module lzwd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          stream_start_i,
  input  logic          in_last_i,
  output logic          cmd_valid_o,
  output lzwd_pkg::cmd_t cmd_o,
  input  logic          cmd_ready_i
);
  import lzwd_pkg::*;

  phase_e      phase_q, phase_d, ph, nxt;
  logic [15:0] flag_q, flag_d, fl, shifted;
  logic [7:0]  high_q, high_d;
  logic [15:0] word;
  logic        accept;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign accept      = in_valid_i && cmd_ready_i;

  // classify the byte and step the parser
  always_comb begin
    ph      = stream_start_i ? PH_FLAG : phase_q;
    fl      = stream_start_i ? 16'h0000 : flag_q;
    shifted = fl >> 1;
    if ((shifted & FLAG_MARK) == 16'h0000) begin
      nxt = PH_FLAG;
    end else begin
      nxt = shifted[0] ? PH_LIT : PH_HIGH;
    end
    word       = {high_q, in_byte_i};
    phase_d    = phase_q;
    flag_d     = flag_q;
    high_d     = high_q;
    cmd_o.kind = CMD_NOP;
    cmd_o.data = in_byte_i;
    cmd_o.pos  = word[9:0];
    cmd_o.cnt  = {1'b0, word[15:10]} + CNT_W'(LEN_BIAS);
    cmd_o.start = stream_start_i;
    cmd_o.last  = in_last_i;
    unique case (ph)
      PH_FLAG: begin
        flag_d  = {8'hFF, in_byte_i};
        phase_d = in_byte_i[0] ? PH_LIT : PH_HIGH;
      end
      PH_LIT: begin
        cmd_o.kind = CMD_LIT;
        flag_d     = shifted;
        phase_d    = nxt;
      end
      PH_HIGH: begin
        high_d  = in_byte_i;
        phase_d = PH_LOW;
      end
      PH_LOW: begin
        cmd_o.kind = CMD_COPY;
        flag_d     = shifted;
        phase_d    = nxt;
      end
      default: begin
        phase_d = PH_FLAG;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FLAG;
      flag_q  <= '0;
      high_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      flag_q  <= flag_d;
      high_q  <= high_d;
    end
  end
endmodule

[hw/rtl/lzwd_back.sv]
// Back end: runs commands against the window and packs result pairs.
module lzwd_back #(
  parameter int unsigned MAX_OUT_BYTES = 131072
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lzwd_pkg::cfg_t    cfg_i,
  input  logic              cmd_valid_i,
  input  lzwd_pkg::cmd_t    cmd_i,
  output logic              cmd_ready_o,
  output logic              res_valid_o,
  output lzwd_pkg::result_t res_o,
  input  logic              res_ready_i
);
  import lzwd_pkg::*;

  localparam int unsigned LW = $clog2(MAX_OUT_BYTES + 1);
  localparam int unsigned IW = LW + 2;

  bstate_e state_q, state_d;
  cmd_t    cmd_q, cmd_d;
  logic [LW-1:0]        rem_q, rem_d, len_new;
  logic signed [IW-1:0] dest_q, dest_d, dest_step, stride_ext, len_ext;
  logic [8:0]           rows_q, rows_d, rows_dec;
  logic [17:0]          used_q, used_d;
  status_e              fin_q, fin_d, fin_st;
  logic [9:0]           wp_q, wp_d, pos_q, pos_d, pos_rel;
  logic [10:0]          fill_q, fill_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 did_q, did_d, vld_q, vld_d;
  logic [7:0]           ba_q, ba_d, bb_q, bb_d;
  logic [16:0]          ia_q, ia_d, ib_q, ib_d;
  logic [1:0]           bn_q, bn_d;
  logic [31:0]          len_wide;
  logic                 in_rng, need_push, can_put, put_en, go;
  logic [7:0]           put_val, ram_rdata;
  logic [16:0]          idx17;
  logic                 ram_re;

  // effective length, range check and next index
  always_comb begin
    len_wide   = 32'(cfg_i.out_length);
    len_new    = (len_wide > 32'(MAX_OUT_BYTES)) ? LW'(MAX_OUT_BYTES) : LW'(len_wide);
    in_rng     = !dest_q[IW-1] && ((LW+1)'(dest_q[IW-2:0]) < (LW+1)'(len_new));
    idx17      = 17'(dest_q[IW-2:0]);
    stride_ext = IW'(cfg_i.row_stride);
    len_ext    = IW'(len_new);
    rows_dec   = rows_q - 9'd1;
    dest_step  = dest_q + stride_ext;
    if (rows_dec == 9'd0) begin
      dest_step = dest_step - (len_ext - IW'(1));
    end
    pos_rel    = pos_q - WIN_START;
    go         = (fin_q == ST_RUN) && (rem_q != '0) && (cnt_q != '0);
    put_val    = (cmd_q.kind == CMD_LIT) ? cmd_q.data : (vld_q ? ram_rdata : 8'h00);
    need_push  = in_rng && (bn_q == 2'd2);
    can_put    = !need_push || res_ready_i;
    fin_st     = fin_q;
    if (fin_st == ST_RUN && did_q && rem_q == '0) begin
      fin_st = ST_DONE;
    end
    if (fin_st == ST_RUN && cmd_q.last) begin
      fin_st = ST_SRC;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (cmd_valid_i) state_d = B_EXEC;
      B_EXEC: begin
        if (fin_q != ST_RUN || cmd_q.kind == CMD_NOP) begin
          state_d = B_FIN;
        end else if (cmd_q.kind == CMD_LIT) begin
          state_d = B_WR;
        end else begin
          state_d = B_RD;
        end
      end
      B_RD:  state_d = go ? B_WR : B_FIN;
      B_WR:  if (can_put) state_d = B_RD;
      B_FIN: if (res_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d  = cmd_q;
    rem_d  = rem_q;
    dest_d = dest_q;
    rows_d = rows_q;
    used_d = used_q;
    fin_d  = fin_q;
    wp_d   = wp_q;
    fill_d = fill_q;
    pos_d  = pos_q;
    cnt_d  = cnt_q;
    did_d  = did_q;
    vld_d  = vld_q;
    ba_d   = ba_q;
    bb_d   = bb_q;
    ia_d   = ia_q;
    ib_d   = ib_q;
    bn_d   = bn_q;
    ram_re = 1'b0;
    put_en = 1'b0;
    cmd_ready_o = (state_q == B_IDLE);
    res_valid_o = 1'b0;
    res_o = '{byte_a: ba_q, index_a: ia_q, byte_b: bb_q, index_b: ib_q,
              pair_count: bn_q, run_last: 1'b0, status: ST_RUN, used_count: 18'd0};
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          ba_d  = '0;
          bb_d  = '0;
          ia_d  = '0;
          ib_d  = '0;
          bn_d  = '0;
          did_d = 1'b0;
          if (cmd_i.start) begin
            rem_d  = len_new;
            dest_d = '0;
            rows_d = cfg_i.column_height;
            used_d = '0;
            fin_d  = (len_new == '0) ? ST_DONE : ST_RUN;
            wp_d   = WIN_START;
            fill_d = '0;
          end
        end
      end
      B_EXEC: begin
        if (fin_q == ST_RUN) begin
          used_d = used_q + 18'd1;
          did_d  = (cmd_q.kind != CMD_NOP);
          pos_d  = cmd_q.pos;
          cnt_d  = (cmd_q.kind == CMD_LIT) ? CNT_W'(1) : cmd_q.cnt;
        end
      end
      B_RD: begin
        if (go) begin
          ram_re = 1'b1;
          vld_d  = ({1'b0, pos_rel} < fill_q);
        end
      end
      B_WR: begin
        res_valid_o = need_push;
        put_en      = can_put;
        if (can_put) begin
          pos_d = pos_q + 10'd1;
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      B_FIN: begin
        res_valid_o      = 1'b1;
        res_o.run_last   = 1'b1;
        res_o.status     = fin_st;
        res_o.used_count = (fin_st == ST_DONE) ? used_q : 18'd0;
        if (res_ready_i) begin
          fin_d = fin_st;
        end
      end
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase

    // store one decoded byte; an in-range byte joins the result pair
    if (put_en) begin
      wp_d   = wp_q + 10'd1;
      fill_d = fill_q[10] ? fill_q : fill_q + 11'd1;
      if (!in_rng) begin
        fin_d = ST_IDX;
      end else begin
        if (bn_q == 2'd2) begin
          ba_d = put_val;
          ia_d = idx17;
          bb_d = '0;
          ib_d = '0;
          bn_d = 2'd1;
        end else if (bn_q == 2'd1) begin
          bb_d = put_val;
          ib_d = idx17;
          bn_d = 2'd2;
        end else begin
          ba_d = put_val;
          ia_d = idx17;
          bn_d = 2'd1;
        end
        rem_d = rem_q - LW'(1);
        if (cfg_i.order_mode) begin
          dest_d = dest_step;
          rows_d = (rows_dec == 9'd0) ? cfg_i.column_height : rows_dec;
        end else begin
          dest_d = dest_q + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      rem_q   <= LW'(1);
      dest_q  <= '0;
      rows_q  <= 9'd1;
      used_q  <= '0;
      fin_q   <= ST_RUN;
      wp_q    <= WIN_START;
      fill_q  <= '0;
      cnt_q   <= '0;
      did_q   <= 1'b0;
      bn_q    <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      dest_q  <= dest_d;
      rows_q  <= rows_d;
      used_q  <= used_d;
      fin_q   <= fin_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      did_q   <= did_d;
      bn_q    <= bn_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    pos_q <= pos_d;
    vld_q <= vld_d;
    ba_q  <= ba_d;
    bb_q  <= bb_d;
    ia_q  <= ia_d;
    ib_q  <= ib_d;
  end

  lzwd_ram #(
    .WIDTH(8),
    .DEPTH(WIN_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (put_en),
    .waddr_i(wp_q),
    .wdata_i(put_val),
    .re_i   (ram_re),
    .raddr_i(pos_q),
    .rdata_o(ram_rdata)
  );
endmodule

[hw/rtl/lz_window_decoder_top.sv]
// LZ window decoder top level: config registers, front, queues and back.
// Usage:
// Input channel (in_valid_i/in_ready_o) takes one compressed byte per
// transfer with stream_start_i and in_last_i. The output channel
// (out_valid_o/out_ready_i) gives up to two decoded bytes per result with
// destination indices, and the step's last result carries run_last_o,
// status_o and used_count_o. Config is written via cfg_we_i, cfg_index_i
// and cfg_wdata_i by the user only while idle; the block does not check it.
// Each byte passes the parser in its accept cycle, a two-entry command
// queue, then the executor, which takes one command at a time from idle
// through exec: a literal is then written, a copy does a window RAM read
// followed by its write-back for each copied byte, and every command,
// flag and high bytes included, ends in fin with its last result.
// Window entries never written since stream start read as zero through a
// fill count, so neither reset nor stream_start needs a clearing pass.
// Reset puts the block at stream start with length, stride and height 1.
// A stalled receiver fills the two-entry result queue and then holds the
// executor; the command queue then fills and in_ready_o drops.
`include "assert_macros.svh"
module lz_window_decoder_top #(
  parameter int unsigned MAX_OUT_BYTES = 131072
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [17:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        stream_start_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  byte_a_o,
  output logic [16:0] index_a_o,
  output logic [7:0]  byte_b_o,
  output logic [16:0] index_b_o,
  output logic [1:0]  pair_count_o,
  output logic        run_last_o,
  output logic [1:0]  status_o,
  output logic [17:0] used_count_o
);
  import lzwd_pkg::*;

  cfg_t    cfg_q;
  cmd_t    cmd_push_data, cmd_pop_data;
  logic    cmd_push_valid, cmd_push_ready, cmd_pop_valid, cmd_pop_ready;
  result_t res_push_data, res_pop_data;
  logic    res_push_valid, res_push_ready;

  // take config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{order_mode: 1'b0, out_length: 18'd1, row_stride: 9'd1,
                 column_height: 9'd1};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ORDER:  cfg_q.order_mode    <= cfg_wdata_i[0];
        CFG_LENGTH: cfg_q.out_length    <= cfg_wdata_i;
        CFG_STRIDE: cfg_q.row_stride    <= cfg_wdata_i[8:0];
        CFG_HEIGHT: cfg_q.column_height <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  lzwd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .stream_start_i(stream_start_i),
    .in_last_i     (in_last_i),
    .cmd_valid_o   (cmd_push_valid),
    .cmd_o         (cmd_push_data),
    .cmd_ready_i   (cmd_push_ready)
  );

  lzwd_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(cmd_push_valid),
    .push_ready_o(cmd_push_ready),
    .push_data_i (cmd_push_data),
    .pop_valid_o (cmd_pop_valid),
    .pop_ready_i (cmd_pop_ready),
    .pop_data_o  (cmd_pop_data)
  );

  lzwd_back #(
    .MAX_OUT_BYTES(MAX_OUT_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_valid_i(cmd_pop_valid),
    .cmd_i      (cmd_pop_data),
    .cmd_ready_o(cmd_pop_ready),
    .res_valid_o(res_push_valid),
    .res_o      (res_push_data),
    .res_ready_i(res_push_ready)
  );

  lzwd_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(res_push_valid),
    .push_ready_o(res_push_ready),
    .push_data_i (res_push_data),
    .pop_valid_o (out_valid_o),
    .pop_ready_i (out_ready_i),
    .pop_data_o  (res_pop_data)
  );

  assign byte_a_o     = res_pop_data.byte_a;
  assign index_a_o    = res_pop_data.index_a;
  assign byte_b_o     = res_pop_data.byte_b;
  assign index_b_o    = res_pop_data.index_b;
  assign pair_count_o = res_pop_data.pair_count;
  assign run_last_o   = res_pop_data.run_last;
  assign status_o     = res_pop_data.status;
  assign used_count_o = res_pop_data.used_count;

  // a final status only rides on the last result of a step
  `LZWD_ASSERT(a_status_on_last, (out_valid_o && status_o != ST_RUN) |-> run_last_o, "status on non-last result")
  // results before the last one of a step are always full pairs
  `LZWD_ASSERT(a_full_pairs, (out_valid_o && !run_last_o) |-> (pair_count_o == 2'd2), "partial pair before last")
  // the consumed count is shown only when done
  `LZWD_ASSERT(a_used_done, (out_valid_o && used_count_o != 18'd0) |-> (status_o == ST_DONE), "used count without done")
  // a transfer into the result queue shows up at the output next cycle
  `LZWD_ASSERT_NEXT(a_res_visible, (res_push_valid && res_push_ready), out_valid_o, "queued result not visible")
endmodule
